// ===== design/hcd_pkg.sv =====
// hcd_pkg: shared types and constants of the chunked body decoder
// no dependencies; imported by the decoder top level and its interfaces
`default_nettype none

package hcd_pkg;

	// fixed widths of the configuration registers and beat fields
	localparam int unsigned MAX_CHUNK_W = 26;
	localparam int unsigned MAX_LINE_W  = 8;
	localparam int unsigned CFG_DATA_W  = 26;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned STATUS_W    = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE  = 1'd1;

	// register reset values
	localparam logic [MAX_CHUNK_W-1:0] MAX_CHUNK_RST = 26'd33554432;
	localparam logic [MAX_LINE_W-1:0]  MAX_LINE_RST  = 8'd128;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_LINE_LONG = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NO_TERM  = 2'd3;

	// characters
	localparam logic [BYTE_W-1:0] CH_CR   = 8'd13;
	localparam logic [BYTE_W-1:0] CH_LF   = 8'd10;
	localparam logic [BYTE_W-1:0] CH_SEMI = 8'd59;

	typedef enum logic [2:0] {
		PH_SIZE = 3'd0,
		PH_DATA = 3'd1,
		PH_CR   = 3'd2,
		PH_LF   = 3'd3,
		PH_DONE = 3'd4,
		PH_ERR  = 3'd5
	} phase_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] val;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
		hex_digit_t r;
		r.is_hex = 1'b1;
		r.val    = c[3:0];
		if (c >= 8'd48 && c <= 8'd57) begin
			r.val = c[3:0];
		end else if ((c >= 8'd65 && c <= 8'd70) || (c >= 8'd97 && c <= 8'd102)) begin
			r.val = c[3:0] + 4'd9;
		end else begin
			r.is_hex = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/hcd_in_if.sv =====
// hcd_in_if: valid/ready channel carrying raw body bytes into the decoder
// depends on hcd_pkg for the byte width
`default_nettype none

interface hcd_in_if
	import hcd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== design/hcd_out_if.sv =====
// hcd_out_if: valid/ready channel carrying one decode result per body byte
// depends on hcd_pkg for field widths
`default_nettype none

interface hcd_out_if
	import hcd_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                payload_valid;
	logic [BYTE_W-1:0]   payload_byte;
	logic [STATUS_W-1:0] status;
	logic                body_complete;

	modport source (output valid, output payload_valid, output payload_byte,
		output status, output body_complete, input ready);
	modport sink (input valid, input payload_valid, input payload_byte,
		input status, input body_complete, output ready);
endinterface

`default_nettype wire

// ===== design/http_chunked_decoder.sv =====
// http_chunked_decoder: byte-serial decoder for an http/1.1 chunked body
// depends on hcd_pkg, hcd_in_if and hcd_out_if
`default_nettype none

// Takes one body byte per clock unless the output stalls, and gives exactly
// one result beat per byte, in order: payload_valid/payload_byte for chunk
// data, the sticky status and body_complete as they stand after that byte.
// A byte is taken into an input register, then one pass of small logic (hex
// decode, a shift-in of the size digit with a limit compare, a count-down of
// the data bytes) updates the decoder state and loads the result register
// once that register is free; the loop through the phase and size registers
// is what sets the rate of one byte per cycle. The input stays ready while
// the result register is empty or being drained.
// Size lines are hex digits, an optional ';' extension, then CR LF; a line
// longer than max_line_bytes, a bad or too-large size, or a missing CR LF
// after the chunk data stops the decoder with an error code. A zero size
// completes the body and all later bytes are passed over with no payload.
// Configuration: cfg_we with cfg_index 0 writes max_chunk_size, index 1
// writes max_line_bytes; write only while no beat is in flight.
module http_chunked_decoder
	import hcd_pkg::*;
#(
	parameter int unsigned COUNT_BITS = 26
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_data,
	hcd_in_if.sink               in_ch,
	hcd_out_if.source            out_ch
);

	// accumulator after shifting in one digit, and the compare width
	localparam int unsigned WIDE_W = COUNT_BITS + 4;
	localparam int unsigned CMP_W  = (WIDE_W > MAX_CHUNK_W) ? WIDE_W : MAX_CHUNK_W;

	// configuration registers
	logic [MAX_CHUNK_W-1:0] max_chunk_q;
	logic [MAX_LINE_W-1:0]  max_line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chunk_q <= MAX_CHUNK_RST;
			max_line_q  <= MAX_LINE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_CHUNK: max_chunk_q <= cfg_data[MAX_CHUNK_W-1:0];
				CFG_MAX_LINE:  max_line_q  <= cfg_data[MAX_LINE_W-1:0];
				default: ;
			endcase
		end
	end

	// input register stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	logic              advance;

	// the byte in stage 1 moves on when the result register is free
	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.data_byte;
		end
	end

	// decoder state
	phase_t                phase_q, phase_d;
	logic [COUNT_BITS-1:0] acc_q, acc_d;
	logic [COUNT_BITS-1:0] left_q, left_d;
	logic [MAX_LINE_W-1:0] len_q, len_d;
	logic                  ext_q, ext_d;
	logic                  cr_q, cr_d;
	logic                  digits_q, digits_d;
	logic                  bad_q, bad_d;
	logic [STATUS_W-1:0]   err_q, err_d;
	logic                  pv_d;

	// size digit path
	hex_digit_t            dig;
	logic [WIDE_W-1:0]     acc_wide;
	logic                  acc_over;
	logic                  bad_eff;
	logic [COUNT_BITS-1:0] left_dec;

	assign dig      = hex_decode(byte_s1);
	assign acc_wide = {acc_q, dig.val};
	assign acc_over = (CMP_W'(acc_wide) > CMP_W'(max_chunk_q))
		|| (acc_wide[WIDE_W-1:COUNT_BITS] != 4'd0);
	// a held CR that is not followed by LF is a bad size char outside the extension
	assign bad_eff  = bad_q || (cr_q && !ext_q);
	assign left_dec = left_q - COUNT_BITS'(1);

	always_comb begin
		phase_d  = phase_q;
		acc_d    = acc_q;
		left_d   = left_q;
		len_d    = len_q;
		ext_d    = ext_q;
		cr_d     = cr_q;
		digits_d = digits_q;
		bad_d    = bad_q;
		err_d    = err_q;
		pv_d     = 1'b0;
		case (phase_q)
			PH_SIZE: begin
				if (cr_q && byte_s1 == CH_LF) begin
					// end of size line
					if (!digits_q || bad_q) begin
						phase_d = PH_ERR;
						err_d   = ST_BAD_SIZE;
					end else if (acc_q == '0) begin
						phase_d = PH_DONE;
					end else begin
						left_d  = acc_q;
						phase_d = PH_DATA;
					end
					acc_d    = '0;
					len_d    = '0;
					ext_d    = 1'b0;
					cr_d     = 1'b0;
					digits_d = 1'b0;
					bad_d    = 1'b0;
				end else if (len_q >= max_line_q) begin
					phase_d  = PH_ERR;
					err_d    = ST_LINE_LONG;
					acc_d    = '0;
					len_d    = '0;
					ext_d    = 1'b0;
					cr_d     = 1'b0;
					digits_d = 1'b0;
					bad_d    = 1'b0;
				end else begin
					len_d = len_q + MAX_LINE_W'(1);
					bad_d = bad_eff;
					cr_d  = 1'b0;
					if (byte_s1 == CH_CR) begin
						cr_d = 1'b1;
					end else if (!ext_q) begin
						if (byte_s1 == CH_SEMI) begin
							ext_d = 1'b1;
						end else if (!dig.is_hex) begin
							bad_d = 1'b1;
						end else begin
							digits_d = 1'b1;
							if (!bad_eff) begin
								if (acc_over) begin
									bad_d = 1'b1;
									acc_d = '0;
								end else begin
									acc_d = acc_wide[COUNT_BITS-1:0];
								end
							end
						end
					end
				end
			end
			PH_DATA: begin
				pv_d   = 1'b1;
				left_d = left_dec;
				if (left_dec == '0) begin
					phase_d = PH_CR;
				end
			end
			PH_CR: begin
				if (byte_s1 == CH_CR) begin
					phase_d = PH_LF;
				end else begin
					phase_d = PH_ERR;
					err_d   = ST_NO_TERM;
				end
			end
			PH_LF: begin
				if (byte_s1 == CH_LF) begin
					phase_d  = PH_SIZE;
					acc_d    = '0;
					len_d    = '0;
					ext_d    = 1'b0;
					cr_d     = 1'b0;
					digits_d = 1'b0;
					bad_d    = 1'b0;
				end else begin
					phase_d = PH_ERR;
					err_d   = ST_NO_TERM;
				end
			end
			PH_DONE: ;
			default: begin
				// error phase holds; a stray code ends up as missing terminator
				if (err_q == ST_OK) begin
					err_d = ST_NO_TERM;
				end
				phase_d = PH_ERR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SIZE;
			acc_q    <= '0;
			left_q   <= '0;
			len_q    <= '0;
			ext_q    <= 1'b0;
			cr_q     <= 1'b0;
			digits_q <= 1'b0;
			bad_q    <= 1'b0;
			err_q    <= ST_OK;
		end else if (advance) begin
			phase_q  <= phase_d;
			acc_q    <= acc_d;
			left_q   <= left_d;
			len_q    <= len_d;
			ext_q    <= ext_d;
			cr_q     <= cr_d;
			digits_q <= digits_d;
			bad_q    <= bad_d;
			err_q    <= err_d;
		end
	end

	// result register
	logic                payload_valid_q;
	logic [BYTE_W-1:0]   payload_byte_q;
	logic [STATUS_W-1:0] status_q;
	logic                body_complete_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			payload_valid_q <= pv_d;
			payload_byte_q  <= pv_d ? byte_s1 : '0;
			status_q        <= err_d;
			body_complete_q <= (phase_d == PH_DONE);
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.payload_valid = payload_valid_q;
	assign out_ch.payload_byte  = payload_byte_q;
	assign out_ch.status        = status_q;
	assign out_ch.body_complete = body_complete_q;

endmodule

`default_nettype wire

// ===== design/hcd_checker.sv =====
// hcd_checker: port-level checks of the chunked body decoder, bound to the top
// depends on hcd_pkg and on the ports of http_chunked_decoder
`default_nettype none

module hcd_checker
	import hcd_pkg::*;
(
	input wire                clk,
	input wire                arst_n,
	input wire                out_valid,
	input wire                out_ready,
	input wire                payload_valid,
	input wire [STATUS_W-1:0] status,
	input wire                body_complete
);

	logic                out_beat;
	logic [STATUS_W-1:0] last_status_q;
	logic                seen_done_q;

	assign out_beat = out_valid && out_ready;

	// what the last delivered result beat showed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_status_q <= ST_OK;
			seen_done_q   <= 1'b0;
		end else if (out_beat) begin
			last_status_q <= status;
			seen_done_q   <= body_complete;
		end
	end

	// a stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// errors are sticky across beats
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && last_status_q != ST_OK |-> status == last_status_q)
		else $error("error status changed after being raised");

	// completion is sticky across beats
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && seen_done_q |-> body_complete && status == ST_OK)
		else $error("completion lost or error after completion");

	// payload only flows while no error and not complete
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_valid |-> status == ST_OK && !body_complete)
		else $error("payload beat with error or after completion");

endmodule

bind http_chunked_decoder hcd_checker u_hcd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.payload_valid (out_ch.payload_valid),
	.status        (out_ch.status),
	.body_complete (out_ch.body_complete)
);

`default_nettype wire

// ===== tb/http_chunked_decoder_tb.sv =====
`timescale 1ns / 1ps
// http_chunked_decoder_tb: self-checking bench for the chunked body decoder
// feeds body bytes, predicts every result beat in lockstep and compares them
// depends on hcd_pkg, hcd_in_if, hcd_out_if and the http_chunked_decoder rtl

module http_chunked_decoder_tb;
	import hcd_pkg::*;

	localparam int unsigned CLK_PERIOD     = 10;
	localparam int unsigned RESET_CYCLES   = 8;
	localparam int unsigned COUNT_BITS     = 26;
	localparam int unsigned PHASE_BYTES    = 300;   // body bytes per limit setting
	localparam int unsigned HOLD_CYCLES    = 400;   // long receiver hold-off
	localparam int unsigned WATCHDOG_LIMIT = 5000;  // cycles with no beat moving
	localparam int unsigned DRAIN_CYCLES   = 8;     // pipeline is two deep

	// body characters that are not already in the package
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [BYTE_W-1:0] CH_LOW_A = 8'h61;
	localparam logic [BYTE_W-1:0] CH_EXT   = 8'h78; // plain extension text

	// one result beat as the decoder reports it
	typedef struct packed {
		logic                payload_valid;
		logic [BYTE_W-1:0]   payload_byte;
		logic [STATUS_W-1:0] status;
		logic                body_complete;
	} beat_t;

	// one row of the directed table; want only counts when typed is set
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              typed;
		beat_t             want;
	} row_t;

	// the way the body is brought to its end; only one per run since
	// completion and errors can only be left by a reset
	typedef enum int unsigned {
		END_ZERO_SIZE,
		END_LONG_LINE,
		END_EMPTY_SIZE,
		END_NON_HEX,
		END_OVER_LIMIT,
		END_OVER_WIDTH,
		END_LONE_CR,
		END_NO_CR,
		END_NO_LF,
		END_LINE_ZERO,
		END_CHUNK_ZERO
	} ending_t;

	localparam beat_t QUIET = '{1'b0, 8'h00, ST_OK, 1'b0};

	// reset limits: size 01 with an extension holding a lone cr, one data
	// byte at the top of the range, then size 02 with a low byte and a cr
	// passed through as payload
	localparam int unsigned N_DIRECTED = 18;
	localparam row_t DIRECTED [N_DIRECTED] = '{
		'{CH_ZERO,         1'b1, QUIET},                          // first beat after reset
		'{CH_ZERO + 8'd1,  1'b0, QUIET},
		'{CH_SEMI,         1'b0, QUIET},
		'{CH_CR,           1'b0, QUIET},                          // lone cr in the extension
		'{CH_EXT,          1'b0, QUIET},
		'{CH_CR,           1'b0, QUIET},
		'{CH_LF,           1'b0, QUIET},
		'{8'hFF,           1'b1, '{1'b1, 8'hFF, ST_OK, 1'b0}},
		'{CH_CR,           1'b0, QUIET},
		'{CH_LF,           1'b0, QUIET},
		'{CH_ZERO,         1'b0, QUIET},
		'{CH_ZERO + 8'd2,  1'b0, QUIET},
		'{CH_CR,           1'b0, QUIET},
		'{CH_LF,           1'b0, QUIET},
		'{8'h00,           1'b1, '{1'b1, 8'h00, ST_OK, 1'b0}},
		'{CH_CR,           1'b1, '{1'b1, CH_CR, ST_OK, 1'b0}},    // cr as plain payload
		'{CH_CR,           1'b0, QUIET},
		'{CH_LF,           1'b0, QUIET}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hcd_in_if  in_ch ();
	hcd_out_if out_ch ();

	http_chunked_decoder #(
		.COUNT_BITS(COUNT_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// decoder state as the bench tracks it
	phase_t                 ph;
	logic [MAX_CHUNK_W-1:0] size_acc;
	logic [MAX_CHUNK_W-1:0] bytes_left;
	logic [MAX_LINE_W-1:0]  line_len;
	logic                   in_ext;
	logic                   held_cr;
	logic                   digits_seen;
	logic                   size_bad;
	logic [STATUS_W-1:0]    err_code;
	logic [MAX_CHUNK_W-1:0] lim_chunk;
	logic [MAX_LINE_W-1:0]  lim_line;

	beat_t       decoded_beats[$];  // beats owed by the decoder, oldest first
	int unsigned mismatches = 0;
	int unsigned bytes_sent = 0;
	int unsigned idle_cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          long_hold = 1'b0;

	// ---------------------------------------------------------------
	// decoder behavior
	// ---------------------------------------------------------------

	// {is hex, value}
	function automatic logic [4:0] hex_nibble(input logic [BYTE_W-1:0] c);
		if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return {1'b1, 4'(c - CH_ZERO)};
		if (c >= CH_UP_A && c <= CH_UP_A + 8'd5) return {1'b1, 4'(c - CH_UP_A + 8'd10)};
		if (c >= CH_LOW_A && c <= CH_LOW_A + 8'd5) return {1'b1, 4'(c - CH_LOW_A + 8'd10)};
		return 5'b0;
	endfunction

	function automatic void clear_size_line();
		size_acc    = '0;
		line_len    = '0;
		in_ext      = 1'b0;
		held_cr     = 1'b0;
		digits_seen = 1'b0;
		size_bad    = 1'b0;
	endfunction

	function automatic void decoder_reset_state();
		lim_chunk  = MAX_CHUNK_RST;
		lim_line   = MAX_LINE_RST;
		ph         = PH_SIZE;
		bytes_left = '0;
		err_code   = ST_OK;
		clear_size_line();
	endfunction

	// one character of the size part; the extension swallows everything
	function automatic void size_line_char(input logic [BYTE_W-1:0] c);
		logic [4:0]  nib;
		logic [31:0] grown;
		if (in_ext) return;
		if (c == CH_SEMI) begin
			in_ext = 1'b1;
			return;
		end
		nib = hex_nibble(c);
		if (!nib[4]) begin
			size_bad = 1'b1;
			return;
		end
		digits_seen = 1'b1;
		if (size_bad) return;
		grown = {2'b0, size_acc, nib[3:0]};
		// above the limit, or too wide for the byte counter
		if (grown > 32'(lim_chunk) || (grown >> COUNT_BITS) != 0) begin
			size_bad = 1'b1;
			size_acc = '0;
		end else begin
			size_acc = grown[MAX_CHUNK_W-1:0];
		end
	endfunction

	function automatic void close_size_line();
		if (!digits_seen || size_bad) begin
			err_code = ST_BAD_SIZE;
			ph       = PH_ERR;
		end else if (size_acc == '0) begin
			ph = PH_DONE;
		end else begin
			bytes_left = size_acc;
			ph         = PH_DATA;
		end
		clear_size_line();
	endfunction

	// the beat one body byte produces, with the state moved on
	function automatic beat_t decode_byte(input logic [BYTE_W-1:0] c);
		beat_t r;
		r = QUIET;
		case (ph)
		PH_SIZE: begin
			if (held_cr && c == CH_LF) begin
				close_size_line();
			end else if (line_len >= lim_line) begin
				err_code = ST_LINE_LONG;
				ph       = PH_ERR;
				clear_size_line();
			end else begin
				line_len = line_len + 8'd1;
				// a cr that did not end the line is an ordinary character
				if (held_cr) begin
					held_cr = 1'b0;
					size_line_char(CH_CR);
				end
				if (c == CH_CR) held_cr = 1'b1;
				else size_line_char(c);
			end
		end
		PH_DATA: begin
			r.payload_valid = 1'b1;
			r.payload_byte  = c;
			bytes_left      = bytes_left - 1'b1;
			if (bytes_left == '0) ph = PH_CR;
		end
		PH_CR: begin
			if (c == CH_CR) begin
				ph = PH_LF;
			end else begin
				err_code = ST_NO_TERM;
				ph       = PH_ERR;
			end
		end
		PH_LF: begin
			if (c == CH_LF) begin
				ph = PH_SIZE;
				clear_size_line();
			end else begin
				err_code = ST_NO_TERM;
				ph       = PH_ERR;
			end
		end
		PH_DONE: begin
		end
		default: begin
			if (err_code == ST_OK) err_code = ST_NO_TERM;
			ph = PH_ERR;
		end
		endcase
		r.status        = err_code;
		r.body_complete = (ph == PH_DONE);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t ns  mismatch: %s", $time, what);
	endtask

	// offer one byte, wait for it to be taken, then book its beat
	task automatic put_byte(input logic [BYTE_W-1:0] b, input logic typed = 1'b0,
		input beat_t want = '0);
		beat_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predicted = decode_byte(b);
		decoded_beats.push_back(typed ? want : predicted);
		bytes_sent++;
	endtask

	// every owed beat back, then let the pipeline empty out
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (decoded_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// limits only change with nothing in flight
	task automatic set_limits(input logic [MAX_CHUNK_W-1:0] chunk,
		input logic [MAX_LINE_W-1:0] line);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MAX_CHUNK;
		cfg_data  <= chunk;
		@(posedge clk);
		cfg_index <= CFG_MAX_LINE;
		cfg_data  <= CFG_DATA_W'(line);
		@(posedge clk);
		cfg_we    <= 1'b0;
		lim_chunk = chunk;
		lim_line  = line;
	endtask

	function automatic int unsigned hex_len(input logic [31:0] v);
		int unsigned n;
		n = 1;
		while (n < 8 && (v >> (4 * n)) != 0) n++;
		return n;
	endfunction

	// digit in either case, picked at random
	function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return CH_ZERO + BYTE_W'(nib);
		return ($urandom_range(0, 1) ? CH_UP_A : CH_LOW_A) + BYTE_W'(nib) - 8'd10;
	endfunction

	task automatic send_size_digits(input logic [31:0] v);
		for (int i = int'(hex_len(v)) - 1; i >= 0; i--) put_byte(hex_char(v[4 * i +: 4]));
	endtask

	// one well-formed chunk: size line with random padding, data, cr lf
	task automatic send_chunk();
		int unsigned size;
		int unsigned room;
		int unsigned pad;
		int unsigned zeros;
		int unsigned k;
		logic [BYTE_W-1:0] c;
		logic [BYTE_W-1:0] prev;
		k = $urandom_range(0, 99);
		if (k < 70) size = $urandom_range(1, 8);
		else if (k < 95) size = $urandom_range(9, 40);
		else size = $urandom_range(41, 200);
		if (size > lim_chunk) size = $urandom_range(1, lim_chunk);
		// a short line limit only leaves room for one digit and the cr
		if (hex_len(size) + 1 > lim_line)
			size = $urandom_range(1, (lim_chunk < 15) ? lim_chunk : 15);
		room = lim_line - hex_len(size) - 1;
		// now and then the line is filled right up to the limit
		k = $urandom_range(0, 99);
		if (k < 40) pad = 0;
		else if (k < 55) pad = room;
		else pad = $urandom_range(0, (room < 10) ? room : 10);
		zeros = $urandom_range(0, pad);
		repeat (zeros) put_byte(CH_ZERO);
		send_size_digits(size);
		if (pad > zeros) begin
			put_byte(CH_SEMI);
			prev = CH_SEMI;
			repeat (pad - zeros - 1) begin
				c = BYTE_W'($urandom_range(0, 255));
				// cr lf would end the line early
				if (prev == CH_CR && c == CH_LF) c = CH_SEMI;
				put_byte(c);
				prev = c;
			end
		end
		put_byte(CH_CR);
		put_byte(CH_LF);
		repeat (size) put_byte(BYTE_W'($urandom_range(0, 255)));
		put_byte(CH_CR);
		put_byte(CH_LF);
	endtask

	// bring the body to completion or to one of the errors, then keep
	// feeding bytes that must change nothing
	task automatic send_ending(input ending_t kind);
		logic [BYTE_W-1:0] c;
		logic [4:0]        nib;
		case (kind)
		END_LONG_LINE: begin
			set_limits(MAX_CHUNK_RST,
				($urandom_range(0, 2) == 0) ? 8'd1 : 8'($urandom_range(1, 255)));
		end
		END_OVER_LIMIT: set_limits(MAX_CHUNK_W'($urandom_range(1, 4095)), MAX_LINE_RST);
		END_OVER_WIDTH: set_limits('1, MAX_LINE_RST);
		END_LINE_ZERO:  set_limits(MAX_CHUNK_RST, '0);
		END_CHUNK_ZERO: set_limits('0, MAX_LINE_RST);
		default:        set_limits(MAX_CHUNK_RST, MAX_LINE_RST);
		endcase
		case (kind)
		END_ZERO_SIZE: begin
			repeat ($urandom_range(1, 3)) put_byte(CH_ZERO);
			if ($urandom_range(0, 1)) begin
				put_byte(CH_SEMI);
				put_byte(CH_EXT);
			end
			put_byte(CH_CR);
			put_byte(CH_LF);
		end
		END_LONG_LINE: begin
			repeat (int'(lim_line) + 1) begin
				do c = BYTE_W'($urandom_range(0, 255)); while (c == CH_CR);
				put_byte(c);
			end
		end
		END_EMPTY_SIZE: begin
			put_byte(CH_CR);
			put_byte(CH_LF);
		end
		END_NON_HEX: begin
			put_byte(CH_ZERO + 8'd1);
			do begin
				c   = BYTE_W'($urandom_range(0, 255));
				nib = hex_nibble(c);
			end while (nib[4] || c == CH_SEMI || c == CH_CR);
			put_byte(c);
			put_byte(CH_CR);
			put_byte(CH_LF);
		end
		END_OVER_LIMIT, END_OVER_WIDTH: begin
			// one past the limit, or one past what the counter holds
			send_size_digits((kind == END_OVER_LIMIT) ? 32'(lim_chunk) + 1 : 32'h0400_0000);
			put_byte(CH_CR);
			put_byte(CH_LF);
		end
		END_LONE_CR: begin
			put_byte(CH_ZERO + 8'd1);
			put_byte(CH_CR);
			put_byte(CH_ZERO + 8'd2);
			put_byte(CH_CR);
			put_byte(CH_LF);
		end
		END_NO_CR, END_NO_LF: begin
			put_byte(CH_ZERO + 8'd1);
			put_byte(CH_CR);
			put_byte(CH_LF);
			put_byte(BYTE_W'($urandom_range(0, 255)));
			if (kind == END_NO_LF) begin
				put_byte(CH_CR);
				do c = BYTE_W'($urandom_range(0, 255)); while (c == CH_LF);
			end else begin
				do c = BYTE_W'($urandom_range(0, 255)); while (c == CH_CR);
			end
			put_byte(c);
		end
		END_CHUNK_ZERO: begin
			put_byte(CH_ZERO + 8'd1);
			put_byte(CH_CR);
			put_byte(CH_LF);
		end
		default: begin
		end
		endcase
		repeat (16) put_byte(BYTE_W'($urandom_range(0, 255)));
	endtask

	// ---------------------------------------------------------------
	// processes
	// ---------------------------------------------------------------

	// receiver: random stalls, plus one long hold-off on request so the
	// decoder backs up and stops taking bytes
	initial begin : receiver
		int unsigned held;
		held         = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold && held < HOLD_CYCLES) begin
				out_ch.ready <= 1'b0;
				held++;
			end else begin
				if (long_hold) begin
					long_hold = 1'b0;
					held      = 0;
				end
				out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// compare every result beat with the oldest one owed
	always @(posedge clk) begin : check_beat
		beat_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (decoded_beats.size() == 0) begin
				report_mismatch("result beat with no byte behind it");
			end else begin
				want = decoded_beats.pop_front();
				if (out_ch.payload_valid !== want.payload_valid)
					report_mismatch($sformatf("payload_valid %b, want %b",
						out_ch.payload_valid, want.payload_valid));
				if (out_ch.payload_byte !== want.payload_byte)
					report_mismatch($sformatf("payload_byte %h, want %h",
						out_ch.payload_byte, want.payload_byte));
				if (out_ch.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						out_ch.status, want.status));
				if (out_ch.body_complete !== want.body_complete)
					report_mismatch($sformatf("body_complete %b, want %b",
						out_ch.body_complete, want.body_complete));
			end
		end
	end

	// watchdog: too long with no beat moving either way
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int unsigned mark;
		ending_t     ending;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_MAX_CHUNK;
		cfg_data        = '0;
		in_ch.valid     = 1'b0;
		in_ch.data_byte = '0;
		decoder_reset_state();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at reset limits, no idling
		foreach (DIRECTED[i]) put_byte(DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].want);

		// random well-formed body under a series of limit settings
		for (int p = 0; p < 6; p++) begin
			case (p)
			0: begin
				set_limits(MAX_CHUNK_RST, MAX_LINE_RST);
				send_idle_pct  = 0;
				recv_stall_pct = 0;
				long_hold      = 1'b1;
			end
			1: begin
				set_limits(26'd1, 8'd255);
				send_idle_pct  = 55;
				recv_stall_pct = 0;
			end
			2: begin
				set_limits('1, 8'd2);
				send_idle_pct  = 0;
				recv_stall_pct = 55;
			end
			3: begin
				set_limits(MAX_CHUNK_W'($urandom_range(16, 300)), 8'($urandom_range(8, 40)));
				send_idle_pct  = 19;
				recv_stall_pct = 19;
			end
			4: begin
				set_limits(MAX_CHUNK_W'($urandom_range(1, 70000)), 8'($urandom_range(3, 255)));
				send_idle_pct  = 55;
				recv_stall_pct = 0;
			end
			default: begin
				set_limits(MAX_CHUNK_RST, 8'd255);
				send_idle_pct  = 0;
				recv_stall_pct = 55;
			end
			endcase
			mark = bytes_sent;
			while (bytes_sent - mark < PHASE_BYTES) send_chunk();
		end

		// the seed picks how this run's body ends
		ending = ending_t'($urandom_range(0, END_CHUNK_ZERO));
		send_ending(ending);

		wait_drained();
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== http_chunked_decoder.f =====
design/hcd_pkg.sv
design/hcd_in_if.sv
design/hcd_out_if.sv
design/http_chunked_decoder.sv
design/hcd_checker.sv
tb/http_chunked_decoder_tb.sv
